// ===== sv/mss_pkg.sv =====
// Shared types, constants, sine table and microprogram of the multitone sine synthesizer.
package mss_pkg;

	localparam int PHASE_BITS = 32;
	localparam int SINE_ADDR_BITS = 10;
	localparam int TONE_COUNT = 3;

	localparam int TONE_BITS = (TONE_COUNT > 1) ? $clog2(TONE_COUNT) : 1;
	localparam int QUARTER_BITS = SINE_ADDR_BITS - 2;
	localparam int QUARTER_LEN = 1 << QUARTER_BITS;
	localparam int SUM_BITS = 33 + $clog2(TONE_COUNT + 1);

	localparam int DAC_BITS = 8;
	localparam int CFG_TONES = 3;
	localparam int STEP_BITS = 32;
	localparam int GAIN_BITS = 16;
	localparam int SHIFT_BITS = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = 48;

	localparam logic [CFG_IDX_BITS-1:0] REG_TONE_ONE_STEP = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TONE_TWO_STEP = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TONE_THREE_STEP = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TONE_ONE_GAIN = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TONE_TWO_GAIN = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_TONE_THREE_GAIN = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_LEVEL_OFFSET = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_PHASE_SHIFTS = 3'd7;

	localparam logic [STEP_BITS-1:0] RST_TONE_ONE_STEP = 32'd12884902;
	localparam logic [STEP_BITS-1:0] RST_TONE_TWO_STEP = 32'd30064771;
	localparam logic [STEP_BITS-1:0] RST_TONE_THREE_STEP = 32'd55834575;
	localparam logic [GAIN_BITS-1:0] RST_TONE_ONE_GAIN = 16'd2560;
	localparam logic [GAIN_BITS-1:0] RST_TONE_TWO_GAIN = 16'd6400;
	localparam logic [GAIN_BITS-1:0] RST_TONE_THREE_GAIN = 16'd3840;
	localparam logic [GAIN_BITS-1:0] RST_LEVEL_OFFSET = 16'd32512;

	typedef struct packed {
		logic [CFG_TONES-1:0][STEP_BITS-1:0] step;
		logic [CFG_TONES-1:0][GAIN_BITS-1:0] gain;
		logic [CFG_TONES-1:0][SHIFT_BITS-1:0] shift;
		logic [GAIN_BITS-1:0] offset;
	} cfg_t;

	// sine quarter table, Q1.15, sampled at bin centers
	typedef logic signed [15:0] sine_rom_t [QUARTER_LEN];

	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	function automatic logic [63:0] q30_mul(input logic [63:0] a, input logic [63:0] b);
		return (a * b) >> 30;
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] v;
		for (int k = 0; k < QUARTER_LEN; k++) begin
			x = (64'(2 * k + 1) * HALF_PI_Q30) >> (SINE_ADDR_BITS - 1);
			x2 = q30_mul(x, x);
			t = Q30_ONE;
			t = Q30_ONE - q30_mul(x2, t) / 64'd110;
			t = Q30_ONE - q30_mul(x2, t) / 64'd72;
			t = Q30_ONE - q30_mul(x2, t) / 64'd42;
			t = Q30_ONE - q30_mul(x2, t) / 64'd20;
			t = Q30_ONE - q30_mul(x2, t) / 64'd6;
			t = q30_mul(x, t);
			v = (t * 64'd32767 + (64'd1 << 29)) >> 30;
			rom[k] = 16'(v);
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// microprogram
	localparam int PC_BITS = 3;
	typedef logic [PC_BITS-1:0] pc_t;

	localparam pc_t STEP_IDLE = 3'd0;
	localparam pc_t STEP_LOOKUP = 3'd1;
	localparam pc_t STEP_MUL = 3'd2;
	localparam pc_t STEP_ACC = 3'd3;
	localparam pc_t STEP_EMIT = 3'd4;

	typedef enum logic [1:0] {
		HOLD_NONE,
		HOLD_INPUT,
		HOLD_OUTPUT
	} hold_t;

	typedef enum logic [1:0] {
		JUMP_NEVER,
		JUMP_ALWAYS,
		JUMP_MORE_TONES
	} jump_t;

	typedef struct packed {
		logic take;
		logic load_acc;
		logic lookup;
		logic mul;
		logic acc;
		logic emit;
		hold_t hold;
		jump_t jump;
		pc_t target;
	} uword_t;

	typedef struct packed {
		uword_t word;
		logic go;
	} ctrl_t;

	typedef struct packed {
		logic more_tones;
		logic out_busy;
	} stat_t;

	function automatic uword_t ucode(input pc_t pc);
		uword_t w;
		w = '{take: 1'b0, load_acc: 1'b0, lookup: 1'b0, mul: 1'b0, acc: 1'b0,
			emit: 1'b0, hold: HOLD_NONE, jump: JUMP_NEVER, target: STEP_IDLE};
		case (pc)
			STEP_IDLE: begin
				w.take = 1'b1;
				w.load_acc = 1'b1;
				w.hold = HOLD_INPUT;
			end
			STEP_LOOKUP: begin
				w.lookup = 1'b1;
			end
			STEP_MUL: begin
				w.mul = 1'b1;
			end
			STEP_ACC: begin
				w.acc = 1'b1;
				w.jump = JUMP_MORE_TONES;
				w.target = STEP_LOOKUP;
			end
			STEP_EMIT: begin
				w.emit = 1'b1;
				w.hold = HOLD_OUTPUT;
				w.jump = JUMP_ALWAYS;
				w.target = STEP_IDLE;
			end
			default: begin
				w.jump = JUMP_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== sv/mss_if.sv =====
// Sample tick and DAC code channel interfaces.
interface mss_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface mss_out_if;
	import mss_pkg::*;
	logic valid;
	logic ready;
	logic [DAC_BITS-1:0] dac_code;
	logic clipped;

	modport source (output valid, output dac_code, output clipped, input ready);
	modport sink (input valid, input dac_code, input clipped, output ready);
endinterface

// ===== sv/multitone_sine_synthesizer_top.sv =====
// Top level of the multitone direct digital sine synthesizer.
// A tick transfer in the idle step is followed by the lookup, mul and acc steps for each tone
// and then the emit step, which loads the DAC code into the output register. A new tick is
// taken only after emit, since the single shared multiplier is walked through tone by tone.
// Reset (arst_n low, asynchronous): phase accumulators zero, registers at defaults,
// program counter at idle, output channel empty.
module multitone_sine_synthesizer_top (
	input logic clk,
	input logic arst_n,
	mss_in_if.sink in_ch,
	mss_out_if.source out_ch,
	input logic cfg_we,
	input logic [mss_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input logic [mss_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import mss_pkg::*;

	cfg_t cfg;
	ctrl_t ctrl;
	stat_t stat;

	// Register file: steps, gains, level offset and packed phase shifts.
	mss_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	// Microprogram per tick:
	//   idle   - wait for a tick transfer, preset accumulator to offset, restart phases if restart is set
	//   lookup - phase plus shift addresses the quarter sine table
	//   mul    - sine times gain into the product register, phase advances
	//   acc    - product added; loops back to lookup until the last tone
	//   emit   - clamp and load the output register, held while it is still full
	mss_sequencer u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.stat(stat),
		.ctrl(ctrl)
	);

	// Ready only in the idle step; the output register lets a new tick start
	// while the previous code still waits for its transfer.
	assign in_ch.ready = ctrl.word.take;

	mss_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.cfg(cfg),
		.restart(in_ch.restart),
		.stat(stat),
		.out_ch(out_ch)
	);
endmodule

// ===== sv/mss_cfg_regs.sv =====
// Configuration register file.
module mss_cfg_regs (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [mss_pkg::CFG_IDX_BITS-1:0] cfg_idx,
	input logic [mss_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output mss_pkg::cfg_t cfg
);
	import mss_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step[0] <= RST_TONE_ONE_STEP;
			cfg_q.step[1] <= RST_TONE_TWO_STEP;
			cfg_q.step[2] <= RST_TONE_THREE_STEP;
			cfg_q.gain[0] <= RST_TONE_ONE_GAIN;
			cfg_q.gain[1] <= RST_TONE_TWO_GAIN;
			cfg_q.gain[2] <= RST_TONE_THREE_GAIN;
			cfg_q.offset <= RST_LEVEL_OFFSET;
			cfg_q.shift <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_TONE_ONE_STEP: cfg_q.step[0] <= cfg_data[STEP_BITS-1:0];
				REG_TONE_TWO_STEP: cfg_q.step[1] <= cfg_data[STEP_BITS-1:0];
				REG_TONE_THREE_STEP: cfg_q.step[2] <= cfg_data[STEP_BITS-1:0];
				REG_TONE_ONE_GAIN: cfg_q.gain[0] <= cfg_data[GAIN_BITS-1:0];
				REG_TONE_TWO_GAIN: cfg_q.gain[1] <= cfg_data[GAIN_BITS-1:0];
				REG_TONE_THREE_GAIN: cfg_q.gain[2] <= cfg_data[GAIN_BITS-1:0];
				REG_LEVEL_OFFSET: cfg_q.offset <= cfg_data[GAIN_BITS-1:0];
				REG_PHASE_SHIFTS: begin
					cfg_q.shift[0] <= cfg_data[15:0];
					cfg_q.shift[1] <= cfg_data[31:16];
					cfg_q.shift[2] <= cfg_data[47:32];
				end
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== sv/mss_sequencer.sv =====
// Microprogram step counter with hold and jump logic.
module mss_sequencer (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input mss_pkg::stat_t stat,
	output mss_pkg::ctrl_t ctrl
);
	import mss_pkg::*;

	pc_t pc_q;
	pc_t pc_d;
	uword_t word;
	logic held;
	logic jump_taken;

	assign word = ucode(pc_q);

	always_comb begin
		case (word.hold)
			HOLD_NONE: held = 1'b0;
			HOLD_INPUT: held = !in_valid;
			HOLD_OUTPUT: held = stat.out_busy;
			default: held = 1'b0;
		endcase
	end

	always_comb begin
		case (word.jump)
			JUMP_NEVER: jump_taken = 1'b0;
			JUMP_ALWAYS: jump_taken = 1'b1;
			JUMP_MORE_TONES: jump_taken = stat.more_tones;
			default: jump_taken = 1'b0;
		endcase
	end

	always_comb begin
		if (held) begin
			pc_d = pc_q;
		end else if (jump_taken) begin
			pc_d = word.target;
		end else begin
			pc_d = pc_q + PC_BITS'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else begin
			pc_q <= pc_d;
		end
	end

	assign ctrl.word = word;
	assign ctrl.go = !held;

	a_hold_keeps_pc: assert property (@(posedge clk) disable iff (!arst_n)
		held |=> pc_q == $past(pc_q))
		else $error("step counter moved while held");
	a_jump_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(!held && jump_taken) |=> pc_q == $past(word.target))
		else $error("jump missed its target");
	a_emit_leads_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_EMIT && !held) |=> pc_q == STEP_IDLE)
		else $error("emit step did not return to idle");
endmodule

// ===== sv/mss_datapath.sv =====
// Phase accumulators, sine lookup, shared multiplier, accumulator and output register.
module mss_datapath (
	input logic clk,
	input logic arst_n,
	input mss_pkg::ctrl_t ctrl,
	input mss_pkg::cfg_t cfg,
	input logic restart,
	output mss_pkg::stat_t stat,
	mss_out_if.source out_ch
);
	import mss_pkg::*;

	localparam logic signed [SUM_BITS-1:0] TOP_LEVEL = SUM_BITS'(255) <<< 23;

	logic [PHASE_BITS-1:0] phase_q [TONE_COUNT];
	logic [TONE_BITS-1:0] tone_q;
	logic signed [15:0] sine_q;
	logic signed [32:0] prod_q;
	logic signed [SUM_BITS-1:0] acc_q;
	logic out_valid_q;
	logic [DAC_BITS-1:0] dac_q;
	logic clipped_q;

	logic [PHASE_BITS-1:0] sel_step;
	logic [GAIN_BITS-1:0] sel_gain;
	logic [SHIFT_BITS-1:0] sel_shift;
	logic [15:0] phase16;
	logic [SINE_ADDR_BITS-1:0] rom_idx;
	logic [1:0] quad;
	logic [QUARTER_BITS-1:0] rom_k;
	logic signed [15:0] rom_val;
	logic fire;
	logic [DAC_BITS-1:0] dac_d;
	logic clipped_d;

	// tones past the configured three run with zero step, gain and shift
	always_comb begin
		sel_step = '0;
		sel_gain = '0;
		sel_shift = '0;
		for (int i = 0; i < CFG_TONES; i++) begin
			if (int'(tone_q) == i) begin
				sel_step = PHASE_BITS'(cfg.step[i]);
				sel_gain = cfg.gain[i];
				sel_shift = cfg.shift[i];
			end
		end
	end

	assign phase16 = phase_q[tone_q][PHASE_BITS-1 -: 16] + sel_shift;
	assign rom_idx = phase16[15 -: SINE_ADDR_BITS];
	assign quad = rom_idx[SINE_ADDR_BITS-1 -: 2];
	assign rom_k = rom_idx[QUARTER_BITS-1:0] ^ {QUARTER_BITS{quad[0]}};
	assign rom_val = quad[1] ? -SINE_ROM[rom_k] : SINE_ROM[rom_k];

	assign fire = ctrl.go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TONE_COUNT; i++) begin
				phase_q[i] <= '0;
			end
			tone_q <= '0;
		end else if (fire) begin
			if (ctrl.word.load_acc) begin
				tone_q <= '0;
				if (restart) begin
					for (int i = 0; i < TONE_COUNT; i++) begin
						phase_q[i] <= '0;
					end
				end
			end
			if (ctrl.word.mul) begin
				phase_q[tone_q] <= phase_q[tone_q] + sel_step;
			end
			if (ctrl.word.acc && stat.more_tones) begin
				tone_q <= tone_q + TONE_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (ctrl.word.load_acc) begin
				acc_q <= $signed({{(SUM_BITS-31){1'b0}}, cfg.offset, 15'b0});
			end
			if (ctrl.word.lookup) begin
				sine_q <= rom_val;
			end
			if (ctrl.word.mul) begin
				prod_q <= sine_q * $signed({1'b0, sel_gain});
			end
			if (ctrl.word.acc) begin
				acc_q <= acc_q + SUM_BITS'(prod_q);
			end
		end
	end

	// clamp to the DAC range, flag clipping
	always_comb begin
		if (acc_q[SUM_BITS-1]) begin
			dac_d = '0;
			clipped_d = 1'b1;
		end else if (acc_q > TOP_LEVEL) begin
			dac_d = '1;
			clipped_d = 1'b1;
		end else begin
			dac_d = acc_q[30:23];
			clipped_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && ctrl.word.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctrl.word.emit) begin
			dac_q <= dac_d;
			clipped_q <= clipped_d;
		end
	end

	assign stat.more_tones = tone_q != TONE_BITS'(TONE_COUNT - 1);
	assign stat.out_busy = out_valid_q && !out_ch.ready;

	assign out_ch.valid = out_valid_q;
	assign out_ch.dac_code = dac_q;
	assign out_ch.clipped = clipped_q;

	a_tone_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tone_q <= TONE_BITS'(TONE_COUNT - 1))
		else $error("tone index past last tone");
	a_emit_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ctrl.word.emit) |=> out_valid_q)
		else $error("emitted sample not presented");
	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && clipped_q) |-> (dac_q == '0 || dac_q == '1))
		else $error("clipped sample not at a rail");
endmodule
